[rtl/lrid_pkg.sv]
package lrid_pkg;

	localparam int DICT_ENTRIES = 2048;
	localparam int DICT_AW      = $clog2(DICT_ENTRIES);
	localparam int CODE_W       = DICT_AW + 1;
	localparam int LEN_W        = DICT_AW + 1;
	localparam int BUF_W        = 24;
	localparam int CNT_W        = 5;
	localparam int CW_W         = 4;

	localparam logic [7:0]        RLE_ESCAPE   = 8'h90;
	localparam logic [CW_W-1:0]   START_WIDTH  = CW_W'(9);
	localparam logic [CODE_W-1:0] START_LIMIT  = CODE_W'(511);
	localparam logic [CODE_W-1:0] FIRST_FREE   = CODE_W'(256);
	localparam logic [CNT_W-1:0]  FULL_LEVEL   = CNT_W'(16);
	localparam logic [CNT_W-1:0]  BYTE_BITS    = CNT_W'(8);

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_PULL  = 2'd1,
		REQ_START = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RSP_ACCEPTED = 2'd0,
		RSP_PIXEL    = 2'd1,
		RSP_STARVED  = 2'd2,
		RSP_FULL     = 2'd3
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_PULL,
		ST_FETCH,
		ST_DEC,
		ST_WALK,
		ST_BYTE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PUSH,
		OP_START,
		OP_IGNORE,
		OP_STARVE,
		OP_NIB,
		OP_REP,
		OP_FETCH,
		OP_DEC,
		OP_WALK,
		OP_BYTE
	} op_t;

	typedef struct packed {
		logic accept;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic nib_valid;
		logic reps_nz;
		logic pos_ge_len;
		logic bits_short;
		logic walk_last;
		logic byte_emits;
		logic out_free;
	} stat_t;

	function automatic logic is_root(input logic [CODE_W-1:0] c);
		return (c < CODE_W'(256)) || (c >= CODE_W'(DICT_ENTRIES));
	endfunction

endpackage

[rtl/lrid_ctrl.sv]
module lrid_ctrl
	import lrid_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.req == REQ_PULL) begin
					state_n = ST_PULL;
				end else if (stat.out_free) begin
					state_n = ST_IDLE;
				end
			end
			ST_PULL: begin
				if (stat.nib_valid || stat.reps_nz) begin
					if (stat.out_free) begin
						state_n = ST_IDLE;
					end
				end else begin
					state_n = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (!stat.pos_ge_len) begin
					state_n = ST_BYTE;
				end else if (!stat.bits_short) begin
					state_n = ST_DEC;
				end else if (stat.out_free) begin
					state_n = ST_IDLE;
				end
			end
			ST_DEC: begin
				state_n = ST_WALK;
			end
			ST_WALK: begin
				if (stat.walk_last) begin
					state_n = ST_FETCH;
				end
			end
			ST_BYTE: begin
				if (!stat.byte_emits) begin
					state_n = ST_PULL;
				end else if (stat.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = 1'b0;
		cmd.op     = OP_NONE;
		busy       = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_DISPATCH: begin
				if (stat.out_free) begin
					unique case (stat.req)
						REQ_PUSH:  cmd.op = OP_PUSH;
						REQ_START: cmd.op = OP_START;
						REQ_NONE:  cmd.op = OP_IGNORE;
						default:   cmd.op = OP_NONE;
					endcase
				end
			end
			ST_PULL: begin
				if (stat.out_free) begin
					if (stat.nib_valid) begin
						cmd.op = OP_NIB;
					end else if (stat.reps_nz) begin
						cmd.op = OP_REP;
					end
				end
			end
			ST_FETCH: begin
				if (!stat.pos_ge_len) begin
					cmd.op = OP_FETCH;
				end else if (stat.bits_short && stat.out_free) begin
					cmd.op = OP_STARVE;
				end
			end
			ST_DEC:  cmd.op = OP_DEC;
			ST_WALK: cmd.op = OP_WALK;
			ST_BYTE: begin
				if (!stat.byte_emits || stat.out_free) begin
					cmd.op = OP_BYTE;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

[rtl/lrid_dp.sv]
module lrid_dp
	import lrid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	input  logic       out_stall,
	output stat_t      stat,
	output logic       out_valid,
	output logic [1:0] status,
	output logic [7:0] pixel
);

	logic [CODE_W+7:0] dict_mem [DICT_ENTRIES];
	logic [7:0]        stk_mem  [DICT_ENTRIES];

	req_t              req_q;
	logic [7:0]        data_q;
	logic [BUF_W-1:0]  bitbuf_q;
	logic [CNT_W-1:0]  bitcnt_q;
	logic [CODE_W-1:0] nfc_q;
	logic [CW_W-1:0]   cw_q;
	logic [CODE_W-1:0] limit_q;
	logic [7:0]        maxw_q;
	logic              byte_mode_q;
	logic [CODE_W-1:0] prev_q;
	logic [CODE_W-1:0] orig_q;
	logic [CODE_W-1:0] code_q;
	logic [7:0]        first_q;
	logic [7:0]        last_q;
	logic [7:0]        reps_q;
	logic              esc_q;
	logic [4:0]        nib_q;
	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [7:0]        pixel_q;

	logic [CODE_W+7:0] dict_rd_q;
	logic [7:0]        stk_rd_q;

	logic [CODE_W-1:0] code_in;
	logic              kwk;
	logic [CODE_W-1:0] dec_code;
	logic [CODE_W-1:0] rd_parent;
	logic [7:0]        rd_char;
	logic              walk_last;
	logic [7:0]        first_new;
	logic [DICT_AW-1:0] dict_raddr;
	logic [LEN_W-1:0]  stk_ridx;
	logic              stk_we;
	logic [DICT_AW-1:0] stk_waddr;
	logic [7:0]        stk_wdata;
	logic              dict_we;
	logic              byte_emits;
	logic [7:0]        emit_val;
	logic [CODE_W-1:0] nfc_n;
	logic [CW_W-1:0]   cw_inc;
	logic [CODE_W:0]   limit_inc;
	logic              out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign code_in    = bitbuf_q[CODE_W-1:0] & limit_q;
	assign kwk        = (code_in >= nfc_q);
	assign dec_code   = kwk ? prev_q : code_in;
	assign rd_parent  = dict_rd_q[CODE_W+7:8];
	assign rd_char    = dict_rd_q[7:0];
	assign walk_last  = is_root(code_q) || (len_q >= LEN_W'(DICT_ENTRIES - 1));
	assign first_new  = is_root(code_q) ? code_q[7:0] : rd_char;
	assign dict_raddr = (cmd.op == OP_DEC) ? dec_code[DICT_AW-1:0] : rd_parent[DICT_AW-1:0];
	assign stk_ridx   = len_q - LEN_W'(1) - pos_q;
	assign dict_we    = (cmd.op == OP_WALK) && walk_last && (nfc_q < CODE_W'(DICT_ENTRIES));
	assign byte_emits = esc_q ? (stk_rd_q == 8'd0) : (stk_rd_q != RLE_ESCAPE);
	assign emit_val   = esc_q ? RLE_ESCAPE : stk_rd_q;
	assign nfc_n      = (nfc_q < CODE_W'(DICT_ENTRIES)) ? nfc_q + CODE_W'(1) : nfc_q;
	assign cw_inc     = cw_q + CW_W'(1);
	assign limit_inc  = ((CODE_W+1)'(1) << cw_inc) - (CODE_W+1)'(1);

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = len_q[DICT_AW-1:0];
		stk_wdata = rd_char;
		if (cmd.op == OP_DEC && kwk) begin
			stk_we    = 1'b1;
			stk_waddr = '0;
			stk_wdata = first_q;
		end else if (cmd.op == OP_WALK) begin
			stk_we    = 1'b1;
			stk_wdata = walk_last ? first_new : rd_char;
		end
	end

	always_comb begin
		stat.req        = req_q;
		stat.nib_valid  = nib_q[4];
		stat.reps_nz    = (reps_q != 8'd0);
		stat.pos_ge_len = (pos_q >= len_q);
		stat.bits_short = (bitcnt_q < CNT_W'(cw_q));
		stat.walk_last  = walk_last;
		stat.byte_emits = byte_emits;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		dict_rd_q <= dict_mem[dict_raddr];
		if (dict_we) begin
			dict_mem[nfc_q[DICT_AW-1:0]] <= {prev_q, first_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FETCH) begin
			stk_rd_q <= stk_mem[stk_ridx[DICT_AW-1:0]];
		end
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req_t'(req_type);
			data_q <= data_byte;
		end
		if (cmd.op == OP_DEC) begin
			orig_q <= code_in;
			code_q <= dec_code;
		end else if (cmd.op == OP_WALK && !walk_last) begin
			code_q <= rd_parent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitbuf_q    <= '0;
			bitcnt_q    <= '0;
			nfc_q       <= FIRST_FREE;
			cw_q        <= START_WIDTH;
			limit_q     <= START_LIMIT;
			maxw_q      <= '0;
			byte_mode_q <= 1'b0;
			prev_q      <= '0;
			first_q     <= '0;
			last_q      <= '0;
			reps_q      <= '0;
			esc_q       <= 1'b0;
			nib_q       <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= RSP_ACCEPTED;
			pixel_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_PUSH: begin
					out_valid_q <= 1'b1;
					pixel_q     <= '0;
					if (bitcnt_q > FULL_LEVEL) begin
						status_q <= RSP_FULL;
					end else begin
						status_q <= RSP_ACCEPTED;
						bitbuf_q <= bitbuf_q | (BUF_W'(data_q) << bitcnt_q);
						bitcnt_q <= bitcnt_q + BYTE_BITS;
					end
				end
				OP_START: begin
					out_valid_q <= 1'b1;
					status_q    <= RSP_ACCEPTED;
					pixel_q     <= '0;
					bitbuf_q    <= '0;
					bitcnt_q    <= '0;
					pos_q       <= '0;
					len_q       <= '0;
					nfc_q       <= FIRST_FREE;
					cw_q        <= START_WIDTH;
					limit_q     <= START_LIMIT;
					prev_q      <= '0;
					first_q     <= '0;
					last_q      <= '0;
					reps_q      <= '0;
					esc_q       <= 1'b0;
					nib_q       <= '0;
					byte_mode_q <= data_q[7];
					maxw_q      <= data_q[7] ? (8'd0 - data_q) : data_q;
				end
				OP_IGNORE, OP_STARVE: begin
					out_valid_q <= 1'b1;
					status_q    <= (cmd.op == OP_STARVE) ? RSP_STARVED : RSP_ACCEPTED;
					pixel_q     <= '0;
				end
				OP_NIB: begin
					out_valid_q <= 1'b1;
					status_q    <= RSP_PIXEL;
					pixel_q     <= {4'd0, nib_q[3:0]};
					nib_q       <= '0;
				end
				OP_REP: begin
					out_valid_q <= 1'b1;
					status_q    <= RSP_PIXEL;
					reps_q      <= reps_q - 8'd1;
					if (byte_mode_q) begin
						pixel_q <= last_q;
					end else begin
						pixel_q <= {4'd0, last_q[3:0]};
						nib_q   <= {1'b1, last_q[7:4]};
					end
				end
				OP_FETCH: begin
					pos_q <= pos_q + LEN_W'(1);
				end
				OP_DEC: begin
					bitbuf_q <= bitbuf_q >> cw_q;
					bitcnt_q <= bitcnt_q - CNT_W'(cw_q);
					len_q    <= kwk ? LEN_W'(1) : '0;
					pos_q    <= '0;
				end
				OP_WALK: begin
					len_q <= len_q + LEN_W'(1);
					if (walk_last) begin
						first_q <= first_new;
						prev_q  <= orig_q;
						pos_q   <= '0;
						nfc_q   <= nfc_n;
						if (nfc_n > limit_q) begin
							if (8'(cw_inc) > maxw_q) begin
								nfc_q   <= FIRST_FREE;
								cw_q    <= START_WIDTH;
								limit_q <= START_LIMIT;
							end else begin
								cw_q    <= cw_inc;
								limit_q <= limit_inc[CODE_W-1:0];
							end
						end
					end
				end
				OP_BYTE: begin
					if (esc_q) begin
						esc_q <= 1'b0;
						if (stk_rd_q != 8'd0) begin
							reps_q <= stk_rd_q - 8'd1;
						end
					end else if (stk_rd_q == RLE_ESCAPE) begin
						esc_q <= 1'b1;
					end
					if (byte_emits) begin
						last_q      <= emit_val;
						out_valid_q <= 1'b1;
						status_q    <= RSP_PIXEL;
						if (byte_mode_q) begin
							pixel_q <= emit_val;
						end else begin
							pixel_q <= {4'd0, emit_val[3:0]};
							nib_q   <= {1'b1, emit_val[7:4]};
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pixel     = pixel_q;

	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= CNT_W'(BUF_W))
		else $error("bit count beyond buffer");

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cw_q >= START_WIDTH) && (CODE_W'(cw_q) <= CODE_W'(CODE_W)))
		else $error("code width out of range");

	a_limit_match: assert property (@(posedge clk) disable iff (!arst_n)
		limit_q == ((CODE_W+1)'(1) << cw_q) - (CODE_W+1)'(1))
		else $error("width limit out of step with code width");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q <= LEN_W'(DICT_ENTRIES)) && (pos_q <= len_q))
		else $error("string stack pointers out of range");

endmodule

[rtl/lzw_rle_image_decoder_unit.sv]
// Decodes an LZW/RLE compressed image one request beat at a time. Push and
// start beats pass through the dispatch state. A pull beat is answered in the
// pull state when a nibble or run repeat is pending, and otherwise reads bytes
// from the string stack in the fetch and byte states; when the stack is empty,
// one code is unpacked from the bit buffer and its dictionary chain is walked
// at one entry per cycle through the single dictionary read port. The
// dictionary and string stack are not cleared at reset or start.
module lzw_rle_image_decoder_unit
	import lrid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] pixel
);

	cmd_t  cmd;
	stat_t stat;
	logic  busy;

	lrid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	lrid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (req_type),
		.data_byte (data_byte),
		.out_stall (out_stall),
		.stat      (stat),
		.out_valid (out_valid),
		.status    (status),
		.pixel     (pixel)
	);

	assign in_stall = busy;

endmodule

[tb/lzw_rle_image_decoder_unit_tb.sv]
module lzw_rle_image_decoder_unit_tb;
	import lrid_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		rsp_t       st;
		logic [7:0] px;
	} pixel_rsp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] req_type = REQ_NONE;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	logic [7:0] pixel;

	lzw_rle_image_decoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pixel(pixel)
	);

	always #5 clk = ~clk;

	// decoder shadow state
	logic [23:0] buf_bits;
	logic [4:0]  buf_cnt;
	logic [11:0] dict_parent [DICT_ENTRIES];
	logic [7:0]  dict_char [DICT_ENTRIES];
	logic [7:0]  str_stack [DICT_ENTRIES];
	logic [11:0] str_pos, str_len, free_code, width_lim, prev_code;
	logic [3:0]  code_w;
	logic [7:0]  max_w;
	logic        byte_px;
	logic [7:0]  first_ch, run_byte, run_left;
	logic        esc_pend;
	logic [4:0]  nib_hold;

	pixel_rsp_t pixel_q[$];
	pixel_rsp_t got;
	int errors = 0;
	int cycles = 0;
	int n_items = 0;
	bit tx_calm = 0, rx_calm = 0;
	int rx_wait = 0;
	int long_hold = 0;

	function automatic logic root_code(input logic [11:0] c);
		return c < 12'd256 || c >= 12'(DICT_ENTRIES);
	endfunction

	function automatic void clear_stream();
		buf_bits = '0; buf_cnt = '0; str_pos = '0; str_len = '0;
		free_code = 12'd256; code_w = 4'd9; width_lim = 12'd511;
		prev_code = '0; first_ch = '0; run_byte = '0; run_left = '0;
		esc_pend = 0; nib_hold = '0;
	endfunction

	function automatic void unpack_code();
		logic [11:0] c, orig;
		int len;
		c = 12'(buf_bits & ((24'd1 << code_w) - 24'd1));
		orig = c;
		buf_bits = buf_bits >> code_w;
		buf_cnt = buf_cnt - 5'(code_w);
		len = 0;
		if (c >= free_code) begin
			str_stack[len] = first_ch;
			len++;
			c = prev_code;
		end
		while (!root_code(c) && len < DICT_ENTRIES - 1) begin
			str_stack[len] = dict_char[c];
			len++;
			c = dict_parent[c];
		end
		first_ch = root_code(c) ? c[7:0] : dict_char[c];
		str_stack[len] = first_ch;
		len++;
		if (free_code < 12'(DICT_ENTRIES)) begin
			dict_parent[free_code] = prev_code;
			dict_char[free_code] = first_ch;
			free_code++;
		end
		if (free_code > width_lim) begin
			code_w++;
			width_lim = 12'((13'd1 << code_w) - 13'd1);
			if (code_w > max_w) begin
				free_code = 12'd256; code_w = 4'd9; width_lim = 12'd511;
			end
		end
		prev_code = orig;
		str_len = 12'(len);
		str_pos = '0;
	endfunction

	function automatic logic next_string_byte(output logic [7:0] b);
		if (str_pos >= str_len) begin
			if (buf_cnt < 5'(code_w))
				return 0;
			unpack_code();
		end
		b = str_stack[str_len - 12'd1 - str_pos];
		str_pos++;
		return 1;
	endfunction

	function automatic logic next_run_byte(output logic [7:0] b);
		logic [7:0] c;
		forever begin
			if (run_left > 0) begin
				run_left--;
				b = run_byte;
				return 1;
			end
			if (!next_string_byte(c))
				return 0;
			if (esc_pend) begin
				esc_pend = 0;
				if (c == 8'h00) begin
					run_byte = RLE_ESCAPE;
					b = RLE_ESCAPE;
					return 1;
				end
				run_left = c - 8'd1;
			end else if (c == RLE_ESCAPE) begin
				esc_pend = 1;
			end else begin
				run_byte = c;
				b = c;
				return 1;
			end
		end
	endfunction

	function automatic pixel_rsp_t decode_beat(input req_t r, input logic [7:0] d);
		pixel_rsp_t e;
		logic [7:0] b;
		e.st = RSP_ACCEPTED;
		e.px = 8'h00;
		case (r)
		REQ_PUSH: begin
			if (buf_cnt > 5'd16) begin
				e.st = RSP_FULL;
			end else begin
				buf_bits = buf_bits | (24'(d) << buf_cnt);
				buf_cnt = buf_cnt + 5'd8;
			end
		end
		REQ_PULL: begin
			if (nib_hold[4]) begin
				e.st = RSP_PIXEL;
				e.px = {4'h0, nib_hold[3:0]};
				nib_hold = '0;
			end else if (!next_run_byte(b)) begin
				e.st = RSP_STARVED;
			end else begin
				e.st = RSP_PIXEL;
				if (byte_px) begin
					e.px = b;
				end else begin
					e.px = {4'h0, b[3:0]};
					nib_hold = {1'b1, b[7:4]};
				end
			end
		end
		REQ_START: begin
			clear_stream();
			byte_px = d[7];
			max_w = d[7] ? 8'(-d) : d;
		end
		default: ;
		endcase
		return e;
	endfunction

	task automatic send_item(input req_t r, input logic [7:0] d, output rsp_t st);
		int gap;
		logic stalled;
		pixel_rsp_t e;
		gap = tx_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		data_byte <= d;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		e = decode_beat(r, d);
		pixel_q.push_back(e);
		st = e.st;
		n_items++;
	endtask

	// code specs: >=0 literal, -1 next free code, -2 live entry, -3 beyond dictionary
	function automatic int pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return $urandom_range(0, 255);
		if (r < 37) return RLE_ESCAPE;
		if (r < 55) return $urandom_range(0, 3);
		if (r < 80) return -2;
		if (r < 93) return -1;
		return -3;
	endfunction

	task automatic run_stream(input logic [7:0] hdr, input int specs[$]);
		logic [7:0] bytes[$];
		longint acc;
		int nacc, nf, cw, lim, mw, c;
		rsp_t st;
		acc = 0; nacc = 0; nf = 256; cw = 9; lim = 511;
		mw = hdr[7] ? int'(8'(-hdr)) : int'(hdr);
		foreach (specs[i]) begin
			c = specs[i];
			if (c == -1) c = nf;
			else if (c == -2) c = nf > 256 ? int'($urandom_range(256, nf - 1))
				: int'($urandom_range(0, 255));
			else if (c == -3) c = cw == 12 ? int'($urandom_range(DICT_ENTRIES, 4095)) : nf;
			acc = acc | (longint'(c) << nacc);
			nacc += cw;
			while (nacc >= 8) begin
				bytes.push_back(acc[7:0]);
				acc = acc >> 8;
				nacc -= 8;
			end
			if (nf < DICT_ENTRIES) nf++;
			if (nf > lim) begin
				cw++;
				lim = (1 << cw) - 1;
				if (cw > mw) begin
					nf = 256; cw = 9; lim = 511;
				end
			end
		end
		if (nacc > 0)
			bytes.push_back(8'(acc | (longint'($urandom_range(0, 255)) << nacc)));
		send_item(REQ_START, hdr, st);
		while (bytes.size() > 0) begin
			c = $urandom_range(0, 99);
			if (c < 3) begin
				send_item(REQ_NONE, 8'($urandom_range(0, 255)), st);
			end else if (c < 58) begin
				send_item(REQ_PUSH, bytes[0], st);
				if (st != RSP_FULL) void'(bytes.pop_front());
			end else begin
				send_item(REQ_PULL, 8'($urandom_range(0, 255)), st);
			end
		end
		do send_item(REQ_PULL, 8'($urandom_range(0, 255)), st); while (st != RSP_STARVED);
	endtask

	function automatic void random_specs(input int n, ref int specs[$]);
		specs.delete();
		repeat (n) specs.push_back(pick_code());
	endfunction

	task automatic test_before_start();
		rsp_t st;
		send_item(REQ_PULL, 8'h00, st);
		send_item(REQ_NONE, 8'hFF, st);
		send_item(REQ_PUSH, 8'h41, st);
		send_item(REQ_PUSH, 8'h00, st);
		repeat (3) send_item(REQ_PULL, 8'hFF, st);
	endtask

	task automatic test_full_buffer();
		rsp_t st;
		send_item(REQ_START, 8'h0C, st);
		send_item(REQ_PUSH, 8'hFF, st);
		send_item(REQ_PUSH, 8'h00, st);
		send_item(REQ_PUSH, 8'h80, st);
		send_item(REQ_PUSH, 8'hAA, st);
		send_item(REQ_PUSH, 8'h55, st);
	endtask

	task automatic test_special_codes();
		int specs[$];
		specs = '{8'h41, -1, -1, RLE_ESCAPE, 0, 8'h42, RLE_ESCAPE, 5, RLE_ESCAPE, 1,
			-2, 8'hFF, 0, RLE_ESCAPE, 2, -2};
		run_stream(8'h80, specs);
		run_stream(8'h08, specs);
	endtask

	task automatic test_headers();
		int specs[$];
		logic [7:0] hdrs[$];
		hdrs = '{8'hF4, 8'h00, 8'hFF, 8'h7F, 8'h81, 8'h0B};
		foreach (hdrs[i]) begin
			random_specs(4, specs);
			run_stream(hdrs[i], specs);
		end
	endtask

	task automatic test_table_restart();
		int specs[$];
		specs.delete();
		repeat (258)
			specs.push_back($urandom_range(0, 15) == 0 ? -2 : int'($urandom_range(0, 127)));
		run_stream(8'hF7, specs);
	endtask

	task automatic test_backpressure();
		int specs[$];
		tx_calm = 1;
		@(negedge clk);
		long_hold = 300;
		@(posedge clk);
		random_specs(12, specs);
		run_stream(8'h0A, specs);
		tx_calm = 0;
	endtask

	task automatic test_random();
		int specs[$];
		int start_n;
		logic [7:0] hdr;
		start_n = n_items;
		while (n_items - start_n < 80) begin
			tx_calm = $urandom_range(0, 3) == 0;
			rx_calm = $urandom_range(0, 3) == 0;
			case ($urandom_range(0, 3))
			0: hdr = 8'($urandom_range(0, 255));
			1: hdr = 8'h80;
			2: hdr = 8'($urandom_range(9, 12));
			default: hdr = 8'(-$urandom_range(9, 12));
			endcase
			random_specs($urandom_range(3, 8), specs);
			run_stream(hdr, specs);
		end
		tx_calm = 0;
		rx_calm = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
			out_stall <= rx_wait != 0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= rx_wait != 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d pixel %02h", status, pixel);
			end else begin
				got = pixel_q.pop_front();
				if (status !== got.st || pixel !== got.px) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected status %0d pixel %02h, got status %0d pixel %02h",
							got.st, got.px, status, pixel);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		foreach (dict_parent[i]) begin
			dict_parent[i] = '0;
			dict_char[i] = '0;
			str_stack[i] = '0;
		end
		clear_stream();
		max_w = '0;
		byte_px = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_start();
		test_full_buffer();
		test_special_codes();
		test_headers();
		test_table_restart();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (pixel_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
rtl/lrid_pkg.sv
rtl/lrid_ctrl.sv
rtl/lrid_dp.sv
rtl/lzw_rle_image_decoder_unit.sv
tb/lzw_rle_image_decoder_unit_tb.sv
